// ===== hw/rtl/brs_pkg.sv =====
package brs_pkg;

	// Field widths fixed by the channel formats.
	localparam int WORD_W   = 64;
	localparam int LEN_W    = 6;
	localparam int INDEX_W  = 5;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 3;

	// Depth of the command queue between the front and back parts.
	localparam int CMD_DEPTH = 2;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD    = 2'd0,
		OP_START   = 2'd1,
		OP_ENTROPY = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ACCEPT    = 3'd0,
		ST_READY     = 3'd1,
		ST_LEN_ERR   = 3'd2,
		ST_RANGE_ERR = 3'd3,
		ST_NORM_ERR  = 3'd4,
		ST_REJECT    = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		ORD_EQUAL   = 2'd0,
		ORD_LESS    = 2'd1,
		ORD_GREATER = 2'd2
	} order_t;

	// Command from the front to the back: either one single-word result or a
	// replay of the candidate store over the given number of words.
	typedef struct packed {
		logic              replay;
		status_t           status;
		logic [LEN_W-1:0]  length;
	} cmd_t;

	// Write port into the candidate store.
	typedef struct packed {
		logic              en;
		logic [LEN_W-1:0]  addr;
		logic [WORD_W-1:0] data;
	} cand_wr_t;

	// Sets every bit below the highest set bit, giving the all-ones mask that
	// covers the bit length of the word.
	function automatic logic [WORD_W-1:0] smear(input logic [WORD_W-1:0] x);
		logic [WORD_W-1:0] y;
		y = x;
		for (int s = 0; s < 6; s++) begin
			y = y | (y >> (1 << s));
		end
		return y;
	endfunction

endpackage

// ===== hw/rtl/brs_channels.sv =====
// Request channel carrying load, start and entropy items.
interface brs_item_if;
	logic                             valid;
	logic                             ready;
	logic [brs_pkg::OP_W-1:0]         opcode;
	logic [brs_pkg::INDEX_W-1:0]      word_index;
	logic [brs_pkg::WORD_W-1:0]       word_value;

	modport source (output valid, output opcode, output word_index, output word_value,
		input ready);
	modport sink (input valid, input opcode, input word_index, input word_value,
		output ready);
endinterface

// Result channel carrying status and accepted words.
interface brs_result_if;
	logic                             valid;
	logic                             ready;
	logic [brs_pkg::STATUS_W-1:0]     status;
	logic [brs_pkg::INDEX_W-1:0]      out_index;
	logic [brs_pkg::WORD_W-1:0]       out_word;
	logic [brs_pkg::LEN_W-1:0]        value_length;
	logic                             last;

	modport source (output valid, output status, output out_index, output out_word,
		output value_length, output last, input ready);
	modport sink (input valid, input status, input out_index, input out_word,
		input value_length, input last, output ready);
endinterface

// ===== hw/rtl/bounded_random_rejection_sampler_core.sv =====
// Bounded uniform sampler by masked rejection.
// Requests arrive on the item channel: a load writes one bound word, a start
// checks bound_length and the top bound word and arms a draw, and entropy
// words then build a candidate lowest word first. The result channel carries
// one status result per start and per rejected candidate, and one result per
// word of an accepted value, with last on the final one.
// bound_length is written through cfg_we / cfg_wdata. The user must write it
// only while the block is idle; the block itself does not enforce this. Each
// request passes the front as a bound store read, then a classify and compare,
// and no new item is taken until the last has left stage one. A single-word
// result is registered in stage one, the command queue and the output register.
// An accepted value is replayed from the candidate store word by word through
// FETCH and EMIT; the item channel is held off until the replay is handed over.
// A two-entry command queue sits between the front and the result sequencer,
// so the front keeps taking requests while the receiver stalls until it fills.
// Reset disarms the draw and clears the mask, counters and bound_length; the
// bound and candidate stores keep no reset value.
module bounded_random_rejection_sampler_core #(
	parameter int MAX_WORDS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [brs_pkg::LEN_W-1:0]   cfg_wdata,
	brs_item_if.sink                    item,
	brs_result_if.source                result
);

	logic [brs_pkg::LEN_W-1:0] bound_length_q;

	logic               f_cmd_valid;
	brs_pkg::cmd_t      f_cmd;
	logic               f_cmd_ready;
	logic               b_cmd_valid;
	brs_pkg::cmd_t      b_cmd;
	logic               b_cmd_ready;
	brs_pkg::cand_wr_t  cand_wr;
	logic               replay_done;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_length_q <= '0;
		end else if (cfg_we) begin
			bound_length_q <= cfg_wdata;
		end
	end

	brs_front #(
		.MAX_WORDS (MAX_WORDS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.bound_length (bound_length_q),
		.cmd_valid    (f_cmd_valid),
		.cmd          (f_cmd),
		.cmd_ready    (f_cmd_ready),
		.cand_wr      (cand_wr),
		.replay_done  (replay_done)
	);

	brs_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_cmd_valid),
		.push_data  (f_cmd),
		.push_ready (f_cmd_ready),
		.pop_valid  (b_cmd_valid),
		.pop_data   (b_cmd),
		.pop_ready  (b_cmd_ready)
	);

	brs_back #(
		.MAX_WORDS (MAX_WORDS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (b_cmd_valid),
		.cmd         (b_cmd),
		.cmd_ready   (b_cmd_ready),
		.cand_wr     (cand_wr),
		.result      (result),
		.replay_done (replay_done)
	);

endmodule

// ===== hw/rtl/brs_front.sv =====
module brs_front #(
	parameter int MAX_WORDS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	brs_item_if.sink                    item,
	input  logic [brs_pkg::LEN_W-1:0]   bound_length,
	output logic                        cmd_valid,
	output brs_pkg::cmd_t               cmd,
	input  logic                        cmd_ready,
	output brs_pkg::cand_wr_t           cand_wr,
	input  logic                        replay_done
);

	localparam int ADDR_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

	logic [brs_pkg::WORD_W-1:0] bound_mem [MAX_WORDS];

	logic                        accept;
	logic [ADDR_W-1:0]           rd_addr;
	logic [brs_pkg::LEN_W-1:0]   rd_full;

	logic                        valid_s1;
	logic [brs_pkg::OP_W-1:0]    opcode_s1;
	logic [brs_pkg::WORD_W-1:0]  value_s1;
	logic [brs_pkg::WORD_W-1:0]  bound_word_s1;

	logic                        armed_q, armed_d;
	logic [brs_pkg::WORD_W-1:0]  mask_q, mask_d;
	logic [brs_pkg::LEN_W-1:0]   words_q, words_d;
	brs_pkg::order_t             order_q, order_d;
	logic [brs_pkg::LEN_W-1:0]   hnz_q, hnz_d;
	logic                        pend_q, pend_set;

	logic [brs_pkg::LEN_W-1:0]   words_inc;
	logic                        is_top;
	logic [brs_pkg::WORD_W-1:0]  word_m;
	brs_pkg::order_t             order_n;
	logic [brs_pkg::LEN_W-1:0]   hnz_n;

	// One request in flight at a time; hold off while a replay is outstanding.
	assign item.ready = !valid_s1 && !pend_q && cmd_ready;
	assign accept     = item.valid && item.ready;

	// A start reads the top bound word, anything else the next word to compare.
	assign rd_full = (item.opcode == brs_pkg::OP_START) ? (bound_length - 6'd1) : words_q;
	assign rd_addr = rd_full[ADDR_W-1:0];

	// Bound store: written by loads, read with a registered port.
	always_ff @(posedge clk) begin
		if (accept && item.opcode == brs_pkg::OP_LOAD && int'(item.word_index) < MAX_WORDS) begin
			bound_mem[ADDR_W'(item.word_index)] <= item.word_value;
		end
		bound_word_s1 <= bound_mem[rd_addr];
	end

	// Stage one holds the accepted request while the bound word is fetched.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1 <= item.opcode;
			value_s1  <= item.word_value;
		end
	end

	// Running comparison of the incoming word against the bound word.
	assign words_inc = words_q + 6'd1;
	assign is_top    = (words_inc == bound_length);
	assign word_m    = is_top ? (value_s1 & mask_q) : value_s1;
	assign hnz_n     = (word_m != '0) ? words_inc : hnz_q;

	always_comb begin
		if (word_m < bound_word_s1) begin
			order_n = brs_pkg::ORD_LESS;
		end else if (word_m > bound_word_s1) begin
			order_n = brs_pkg::ORD_GREATER;
		end else begin
			order_n = order_q;
		end
	end

	// Classify the request in stage one and update the draw state.
	always_comb begin
		armed_d   = armed_q;
		mask_d    = mask_q;
		words_d   = words_q;
		order_d   = order_q;
		hnz_d     = hnz_q;
		pend_set  = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '{replay: 1'b0, status: brs_pkg::ST_ACCEPT, length: '0};
		cand_wr   = '{en: 1'b0, addr: words_q, data: word_m};

		if (valid_s1) begin
			case (opcode_s1)
				brs_pkg::OP_LOAD: begin
					armed_d = 1'b0;
					words_d = '0;
					order_d = brs_pkg::ORD_EQUAL;
					hnz_d   = '0;
				end
				brs_pkg::OP_START: begin
					armed_d   = 1'b0;
					words_d   = '0;
					order_d   = brs_pkg::ORD_EQUAL;
					hnz_d     = '0;
					cmd_valid = 1'b1;
					if (int'(bound_length) > MAX_WORDS) begin
						cmd.status = brs_pkg::ST_LEN_ERR;
					end else if (bound_length == '0) begin
						cmd.status = brs_pkg::ST_RANGE_ERR;
					end else if (bound_word_s1 == '0) begin
						cmd.status = brs_pkg::ST_NORM_ERR;
					end else begin
						cmd.status = brs_pkg::ST_READY;
						armed_d    = 1'b1;
						mask_d     = brs_pkg::smear(bound_word_s1);
					end
				end
				brs_pkg::OP_ENTROPY: begin
					if (armed_q) begin
						// A draw that has run past the bound or the store is dropped.
						if (words_q >= bound_length || int'(words_q) >= MAX_WORDS) begin
							armed_d = 1'b0;
							words_d = '0;
							order_d = brs_pkg::ORD_EQUAL;
							hnz_d   = '0;
						end else begin
							cand_wr.en = 1'b1;
							if (is_top) begin
								words_d   = '0;
								order_d   = brs_pkg::ORD_EQUAL;
								hnz_d     = '0;
								cmd_valid = 1'b1;
								if (order_n != brs_pkg::ORD_LESS) begin
									cmd.status = brs_pkg::ST_REJECT;
								end else begin
									armed_d = 1'b0;
									if (hnz_n != '0) begin
										cmd.replay = 1'b1;
										cmd.length = hnz_n;
										pend_set   = 1'b1;
									end
								end
							end else begin
								words_d = words_inc;
								order_d = order_n;
								hnz_d   = hnz_n;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Draw state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			mask_q  <= '0;
			words_q <= '0;
			order_q <= brs_pkg::ORD_EQUAL;
			hnz_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			armed_q <= armed_d;
			mask_q  <= mask_d;
			words_q <= words_d;
			order_q <= order_d;
			hnz_q   <= hnz_d;
			if (pend_set) begin
				pend_q <= 1'b1;
			end else if (replay_done) begin
				pend_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/brs_cmd_fifo.sv =====
module brs_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  brs_pkg::cmd_t  push_data,
	output logic           push_ready,
	output logic           pop_valid,
	output brs_pkg::cmd_t  pop_data,
	input  logic           pop_ready
);

	localparam int PTR_W = (brs_pkg::CMD_DEPTH > 1) ? $clog2(brs_pkg::CMD_DEPTH) : 1;
	localparam int CNT_W = $clog2(brs_pkg::CMD_DEPTH + 1);

	brs_pkg::cmd_t     entries_q [brs_pkg::CMD_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (int'(count_q) < brs_pkg::CMD_DEPTH);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == brs_pkg::CMD_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == brs_pkg::CMD_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/brs_back.sv =====
module brs_back #(
	parameter int MAX_WORDS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  brs_pkg::cmd_t      cmd,
	output logic               cmd_ready,
	input  brs_pkg::cand_wr_t  cand_wr,
	brs_result_if.source       result,
	output logic               replay_done
);

	localparam int ADDR_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

	typedef enum logic [1:0] {
		IDLE,
		FETCH,
		EMIT
	} state_t;

	logic [brs_pkg::WORD_W-1:0] cand_mem [MAX_WORDS];
	logic [brs_pkg::WORD_W-1:0] cand_rdata_q;

	state_t                      state_q;
	logic [brs_pkg::LEN_W-1:0]   k_q;
	logic [brs_pkg::LEN_W-1:0]   len_q;
	logic                        out_valid_q;
	brs_pkg::status_t            status_q;
	logic [brs_pkg::INDEX_W-1:0] index_q;
	logic [brs_pkg::WORD_W-1:0]  word_q;
	logic [brs_pkg::LEN_W-1:0]   vlen_q;
	logic                        last_q;
	logic                        done_q;
	logic                        out_free;
	logic                        k_last;
	logic                        take_cmd;
	logic                        load_out;

	// Candidate store: written by the front, read at the replay position.
	always_ff @(posedge clk) begin
		if (cand_wr.en) begin
			cand_mem[cand_wr.addr[ADDR_W-1:0]] <= cand_wr.data;
		end
		cand_rdata_q <= cand_mem[k_q[ADDR_W-1:0]];
	end

	assign out_free  = !out_valid_q || result.ready;
	assign cmd_ready = (state_q == IDLE) && out_free;
	assign k_last    = ((k_q + 6'd1) == len_q);
	assign take_cmd  = cmd_valid && cmd_ready;
	assign load_out  = (take_cmd && !cmd.replay) || ((state_q == EMIT) && out_free);

	assign result.valid        = out_valid_q;
	assign result.status       = status_q;
	assign result.out_index    = index_q;
	assign result.out_word     = word_q;
	assign result.value_length = vlen_q;
	assign result.last         = last_q;
	assign replay_done         = done_q;

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			k_q         <= '0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
			status_q    <= brs_pkg::ST_ACCEPT;
			index_q     <= '0;
			word_q      <= '0;
			vlen_q      <= '0;
			last_q      <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			// The output slot fills on a new result and empties once it is taken.
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			done_q <= (state_q == EMIT) && out_free && k_last;
			case (state_q)
				IDLE: begin
					if (take_cmd) begin
						if (cmd.replay) begin
							len_q   <= cmd.length;
							k_q     <= '0;
							state_q <= FETCH;
						end else begin
							status_q    <= cmd.status;
							index_q     <= '0;
							word_q      <= '0;
							vlen_q      <= '0;
							last_q      <= 1'b1;
						end
					end
				end
				FETCH: begin
					state_q <= EMIT;
				end
				EMIT: begin
					if (out_free) begin
						status_q    <= brs_pkg::ST_ACCEPT;
						index_q     <= k_q[brs_pkg::INDEX_W-1:0];
						word_q      <= cand_rdata_q;
						vlen_q      <= len_q;
						last_q      <= k_last;
						if (k_last) begin
							state_q <= IDLE;
						end else begin
							k_q     <= k_q + 6'd1;
							state_q <= FETCH;
						end
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule
